>>> hw/rtl/crp_pkg.sv
// Package for the cube rotate and project block: widths, register indexes,
// corner sign table, datapath operation codes and the controller state type.
// Depends on nothing; every other file of the block but crp_div uses it.
`timescale 1ns / 1ps

package crp_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int NUM_CORNERS   = 8;
  localparam int NUM_DIMS      = 3;
  localparam int MAT_FRAC      = 14;
  localparam int BASIS_W       = 18;
  localparam int CORNER_W      = 20;
  localparam int MUL_A_W       = 20;
  localparam int MUL_B_W       = 19;
  localparam int PROD_W        = MUL_A_W + MUL_B_W;
  localparam int DEPTH_W       = 8;
  localparam int SCALE_W       = 10;
  localparam int CTR_W         = 12;
  localparam int DS_W          = DEPTH_W + SCALE_W;
  localparam int NUM_W         = 37;
  localparam int CFG_W         = 48;
  localparam int CFG_IDX_W     = 3;
  localparam int SCR_W         = 16;
  localparam int MASK_W        = 6;
  localparam int IDX_W         = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MROW0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MROW1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MROW2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_X  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_Y  = 3'd6;

  // Bit v set means basis vector v enters the corner negated.
  localparam logic [NUM_DIMS-1:0] CORNER_NEG [NUM_CORNERS] = '{
    3'b000, 3'b010, 3'b110, 3'b100, 3'b101, 3'b001, 3'b011, 3'b111
  };

  localparam logic [IDX_W-1:0] LAST_CORNER = 3'd7;
  localparam logic [1:0]       LAST_DIM    = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_IDENT,
    OP_ROT_MUL,
    OP_ROT_ACC,
    OP_ROT_SAT,
    OP_DS_MUL,
    OP_DS_ST,
    OP_FACE_MUL,
    OP_FACE_CMP,
    OP_CORNER,
    OP_MUL_C,
    OP_DIV_GO,
    OP_DIV_ST,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IDENT,
    ST_ROT_MUL,
    ST_ROT_ACC,
    ST_ROT_SAT,
    ST_DS_MUL,
    ST_DS_ST,
    ST_FACE_MUL,
    ST_FACE_CMP,
    ST_CORNER,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DIV_ST,
    ST_EMIT
  } state_t;

  typedef struct packed {
    dp_op_t           op;
    logic [1:0]       v;
    logic [1:0]       i;
    logic [1:0]       j;
    logic [IDX_W-1:0] k;
    logic             axis;
  } crp_cmd_t;

  typedef struct packed {
    logic clip;
    logic div_busy;
    logic out_free;
  } crp_stat_t;

endpackage

>>> hw/rtl/crp_if.sv
// Channel interfaces of the cube rotate and project block: frame input and
// corner result, each with valid, ready and payload. Depends on crp_pkg.
`timescale 1ns / 1ps

interface crp_in_if;
  logic valid;
  logic ready;
  logic do_rotate;
  logic restart;

  modport source (output valid, output do_rotate, output restart, input ready);
  modport sink (input valid, input do_rotate, input restart, output ready);
endinterface

interface crp_out_if;
  logic                              valid;
  logic                              ready;
  logic        [crp_pkg::IDX_W-1:0]  corner_index;
  logic signed [crp_pkg::SCR_W-1:0]  screen_x;
  logic signed [crp_pkg::SCR_W-1:0]  screen_y;
  logic                              clipped;
  logic        [crp_pkg::MASK_W-1:0] face_mask;
  logic                              last_corner;

  modport source (output valid, output corner_index, output screen_x, output screen_y,
                  output clipped, output face_mask, output last_corner, input ready);
  modport sink (input valid, input corner_index, input screen_x, input screen_y,
                input clipped, input face_mask, input last_corner, output ready);
endinterface

>>> hw/rtl/cube_rotate_project.sv
// Top level of the cube rotate and project block: one frame transaction in,
// eight corner transactions out; a new frame is taken only when the block is idle.
// Restart adds an identity load and rotation adds the rotation steps;
// a clipped corner skips the division.
// Synchronous active-low reset restores the identity basis and register defaults.
// Depends on crp_pkg, crp_if, crp_ctrl, crp_dp and crp_div.
`timescale 1ns / 1ps

module cube_rotate_project #(
  parameter int FRAC_BITS = crp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  crp_in_if.sink                        in_ch,
  crp_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [crp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [crp_pkg::CFG_W-1:0]     cfg_data
);

  // The controller walks one frame at a time: an optional identity load, the
  // 27 multiply-accumulate steps of the rotation, the depth-times-scale
  // product, three face tests and then eight corners. An unclipped corner takes
  // a multiply, a division and a centre-add for x and then for y; a clipped one
  // only a multiply. Each is placed in the output register. The input channel
  // is ready only while the controller is idle, so a new frame transaction can
  // be taken while the last corner still waits in the output register.

  crp_pkg::crp_cmd_t  cmd;
  crp_pkg::crp_stat_t stat;

  crp_ctrl u_crp_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath holds the configuration registers as well; the user must write
  // them only while the block is idle, which the block itself does not enforce.
  crp_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_crp_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .out_ch   (out_ch)
  );

endmodule

>>> hw/rtl/crp_div.sv
// Bit-serial restoring divider for the projection, one quotient bit a cycle.
// Depends on crp_pkg for nothing but is sized by its parameters.
`timescale 1ns / 1ps

module crp_div #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 23
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] sh_r, sh_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             fit;

  always_comb begin
    trial   = {rem_r, sh_r[NUM_W-1]};
    fit     = trial >= {1'b0, den_r};
    cnt_nxt = cnt_r;
    sh_nxt  = sh_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CNT_W'(NUM_W);
      sh_nxt  = num;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      sh_nxt  = {sh_r[NUM_W-2:0], fit};
      rem_nxt = fit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = cnt_r != '0;
  assign quo  = sh_r;

endmodule

>>> hw/rtl/crp_ctrl.sv
// Controller of the cube rotate and project block: sequences rotation,
// face test and the eight corner projections. Depends on crp_pkg and crp_if.
`timescale 1ns / 1ps

module crp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  crp_in_if.sink             in_ch,
  input  crp_pkg::crp_stat_t stat,
  output crp_pkg::crp_cmd_t  cmd
);

  crp_pkg::state_t state_r, state_nxt;
  logic [1:0]                v_r, v_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [crp_pkg::IDX_W-1:0] k_r, k_nxt;
  logic                      axis_r, axis_nxt;
  logic                      rot_r, rot_nxt;

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    axis_nxt  = axis_r;
    rot_nxt   = rot_r;
    case (state_r)
      crp_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          rot_nxt = in_ch.do_rotate;
          v_nxt = '0;
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
          axis_nxt = 1'b0;
          if (in_ch.restart) state_nxt = crp_pkg::ST_IDENT;
          else if (in_ch.do_rotate) state_nxt = crp_pkg::ST_ROT_MUL;
          else state_nxt = crp_pkg::ST_DS_MUL;
        end
      end
      crp_pkg::ST_IDENT: begin
        state_nxt = rot_r ? crp_pkg::ST_ROT_MUL : crp_pkg::ST_DS_MUL;
      end
      crp_pkg::ST_ROT_MUL: state_nxt = crp_pkg::ST_ROT_ACC;
      crp_pkg::ST_ROT_ACC: begin
        if (j_r == crp_pkg::LAST_DIM) begin
          j_nxt = '0;
          state_nxt = crp_pkg::ST_ROT_SAT;
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = crp_pkg::ST_ROT_MUL;
        end
      end
      crp_pkg::ST_ROT_SAT: begin
        if (i_r == crp_pkg::LAST_DIM) begin
          i_nxt = '0;
          if (v_r == crp_pkg::LAST_DIM) begin
            v_nxt = '0;
            state_nxt = crp_pkg::ST_DS_MUL;
          end else begin
            v_nxt = v_r + 1'b1;
            state_nxt = crp_pkg::ST_ROT_MUL;
          end
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = crp_pkg::ST_ROT_MUL;
        end
      end
      crp_pkg::ST_DS_MUL: state_nxt = crp_pkg::ST_DS_ST;
      crp_pkg::ST_DS_ST: state_nxt = crp_pkg::ST_FACE_MUL;
      crp_pkg::ST_FACE_MUL: state_nxt = crp_pkg::ST_FACE_CMP;
      crp_pkg::ST_FACE_CMP: begin
        if (v_r == crp_pkg::LAST_DIM) begin
          v_nxt = '0;
          state_nxt = crp_pkg::ST_CORNER;
        end else begin
          v_nxt = v_r + 1'b1;
          state_nxt = crp_pkg::ST_FACE_MUL;
        end
      end
      crp_pkg::ST_CORNER: state_nxt = crp_pkg::ST_MUL;
      crp_pkg::ST_MUL: begin
        state_nxt = stat.clip ? crp_pkg::ST_EMIT : crp_pkg::ST_DIV_GO;
      end
      crp_pkg::ST_DIV_GO: state_nxt = crp_pkg::ST_DIV_WAIT;
      crp_pkg::ST_DIV_WAIT: begin
        if (!stat.div_busy) state_nxt = crp_pkg::ST_DIV_ST;
      end
      crp_pkg::ST_DIV_ST: begin
        if (axis_r) begin
          axis_nxt = 1'b0;
          state_nxt = crp_pkg::ST_EMIT;
        end else begin
          axis_nxt = 1'b1;
          state_nxt = crp_pkg::ST_MUL;
        end
      end
      crp_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          axis_nxt = 1'b0;
          if (k_r == crp_pkg::LAST_CORNER) begin
            state_nxt = crp_pkg::ST_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
            state_nxt = crp_pkg::ST_CORNER;
          end
        end
      end
      default: state_nxt = crp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.op   = crp_pkg::OP_NONE;
    cmd.v    = v_r;
    cmd.i    = i_r;
    cmd.j    = j_r;
    cmd.k    = k_r;
    cmd.axis = axis_r;
    in_ch.ready = 1'b0;
    case (state_r)
      crp_pkg::ST_IDLE:     in_ch.ready = 1'b1;
      crp_pkg::ST_IDENT:    cmd.op = crp_pkg::OP_IDENT;
      crp_pkg::ST_ROT_MUL:  cmd.op = crp_pkg::OP_ROT_MUL;
      crp_pkg::ST_ROT_ACC:  cmd.op = crp_pkg::OP_ROT_ACC;
      crp_pkg::ST_ROT_SAT:  cmd.op = crp_pkg::OP_ROT_SAT;
      crp_pkg::ST_DS_MUL:   cmd.op = crp_pkg::OP_DS_MUL;
      crp_pkg::ST_DS_ST:    cmd.op = crp_pkg::OP_DS_ST;
      crp_pkg::ST_FACE_MUL: cmd.op = crp_pkg::OP_FACE_MUL;
      crp_pkg::ST_FACE_CMP: cmd.op = crp_pkg::OP_FACE_CMP;
      crp_pkg::ST_CORNER:   cmd.op = crp_pkg::OP_CORNER;
      crp_pkg::ST_MUL:      cmd.op = crp_pkg::OP_MUL_C;
      crp_pkg::ST_DIV_GO:   cmd.op = crp_pkg::OP_DIV_GO;
      crp_pkg::ST_DIV_WAIT: cmd.op = crp_pkg::OP_NONE;
      crp_pkg::ST_DIV_ST:   cmd.op = crp_pkg::OP_DIV_ST;
      crp_pkg::ST_EMIT: begin
        cmd.op = stat.out_free ? crp_pkg::OP_EMIT : crp_pkg::OP_NONE;
      end
      default:              cmd.op = crp_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crp_pkg::ST_IDLE;
      v_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      axis_r  <= 1'b0;
      rot_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v_r     <= v_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      axis_r  <= axis_nxt;
      rot_r   <= rot_nxt;
    end
  end

endmodule

>>> hw/rtl/crp_dp.sv
// Datapath of the cube rotate and project block: configuration registers,
// basis, shared multiplier, divider and output register.
// Depends on crp_pkg, crp_if and crp_div.
`timescale 1ns / 1ps

module crp_dp #(
  parameter int FRAC_BITS = crp_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  crp_pkg::crp_cmd_t               cmd,
  output crp_pkg::crp_stat_t              stat,
  input  logic                            cfg_we,
  input  logic [crp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [crp_pkg::CFG_W-1:0]       cfg_data,
  crp_out_if.source                       out_ch
);

  localparam int BW     = crp_pkg::BASIS_W;
  localparam int CW     = crp_pkg::CORNER_W;
  localparam int PW     = crp_pkg::PROD_W;
  localparam int DEN_W  = crp_pkg::DEPTH_W + FRAC_BITS + 2;
  localparam int DIV_W  = DEN_W - 1;
  localparam int NW     = crp_pkg::NUM_W;
  localparam int SUM_W  = NW + 2;
  localparam int SW     = crp_pkg::SCR_W;
  localparam logic signed [BW-1:0] BASIS_ONE = (FRAC_BITS >= BW - 1) ?
      {1'b0, {(BW-1){1'b1}}} : BW'(1) << FRAC_BITS;
  localparam logic signed [BW-1:0] BASIS_MAX = {1'b0, {(BW-1){1'b1}}};
  localparam logic signed [BW-1:0] BASIS_MIN = {1'b1, {(BW-1){1'b0}}};
  localparam logic signed [PW-1:0] FACE_ONE  = PW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] ROUND_C   = PW'(1) << (crp_pkg::MAT_FRAC - 1);
  localparam logic signed [SUM_W-1:0] SCR_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SCR_MIN = -SUM_W'(32768);

  // Configuration registers.
  logic [crp_pkg::CFG_W-1:0]   mrow_r [crp_pkg::NUM_DIMS];
  logic [crp_pkg::DEPTH_W-1:0] depth_r;
  logic [crp_pkg::SCALE_W-1:0] scale_r;
  logic [crp_pkg::CTR_W-1:0]   ctrx_r, ctry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mrow_r[0] <= '0;
      mrow_r[1] <= '0;
      mrow_r[2] <= '0;
      depth_r   <= 8'd5;
      scale_r   <= 10'd200;
      ctrx_r    <= 12'd600;
      ctry_r    <= 12'd400;
    end else if (cfg_we) begin
      case (cfg_idx)
        crp_pkg::REG_MROW0: mrow_r[0] <= cfg_data;
        crp_pkg::REG_MROW1: mrow_r[1] <= cfg_data;
        crp_pkg::REG_MROW2: mrow_r[2] <= cfg_data;
        crp_pkg::REG_DEPTH: depth_r <= cfg_data[crp_pkg::DEPTH_W-1:0];
        crp_pkg::REG_SCALE: scale_r <= cfg_data[crp_pkg::SCALE_W-1:0];
        crp_pkg::REG_CTR_X: ctrx_r <= cfg_data[crp_pkg::CTR_W-1:0];
        crp_pkg::REG_CTR_Y: ctry_r <= cfg_data[crp_pkg::CTR_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [BW-1:0] b_r   [crp_pkg::NUM_DIMS][crp_pkg::NUM_DIMS];
  logic signed [BW-1:0] tmp_r [2];
  logic signed [PW-1:0] prod_r, prod_nxt, acc_r;
  logic signed [crp_pkg::MUL_A_W-1:0] mul_a;
  logic signed [crp_pkg::MUL_B_W-1:0] mul_b;
  logic signed [15:0]   m_ent;
  logic signed [BW-1:0] b_sel, rnew;
  logic signed [PW-1:0] acc_sh;
  logic [crp_pkg::DS_W-1:0]   ds_r;
  logic [crp_pkg::MASK_W-1:0] mask_r;
  logic signed [CW-1:0] c_nxt [crp_pkg::NUM_DIMS];
  logic signed [CW-1:0] c_r   [2];
  logic signed [DEN_W-1:0] den_nxt, den_r;
  logic                 clip_r, nneg_r;
  logic [crp_pkg::NUM_DIMS-1:0] neg;
  logic signed [PW-1:0] mag;
  logic [NW-1:0]        quo;
  logic                 div_busy;
  logic signed [SUM_W-1:0] q_s, sum_s;
  logic signed [SW-1:0] sat_s;
  logic signed [SW-1:0] scr_r [2];
  logic                 pos_f, neg_f;
  logic                 out_valid_r;

  assign m_ent = mrow_r[cmd.i][16*cmd.j +: 16];
  assign b_sel = b_r[cmd.v][cmd.j];

  // Shared multiplier; its register runs freely and is read in the cycle after its operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      crp_pkg::OP_ROT_MUL: begin
        mul_a = crp_pkg::MUL_A_W'(b_sel);
        mul_b = crp_pkg::MUL_B_W'(m_ent);
      end
      crp_pkg::OP_DS_MUL: begin
        mul_a = crp_pkg::MUL_A_W'(depth_r);
        mul_b = crp_pkg::MUL_B_W'(scale_r);
      end
      crp_pkg::OP_FACE_MUL: begin
        mul_a = crp_pkg::MUL_A_W'(b_r[cmd.v][2]);
        mul_b = crp_pkg::MUL_B_W'(depth_r);
      end
      crp_pkg::OP_MUL_C: begin
        mul_a = c_r[cmd.axis];
        mul_b = $signed({1'b0, ds_r});
      end
      default: ;
    endcase
    prod_nxt = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Rotation accumulate, round and saturate.
  always_comb begin
    acc_sh = acc_r >>> crp_pkg::MAT_FRAC;
    if (acc_sh > PW'(BASIS_MAX)) rnew = BASIS_MAX;
    else if (acc_sh < PW'(BASIS_MIN)) rnew = BASIS_MIN;
    else rnew = acc_sh[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == crp_pkg::OP_ROT_MUL && cmd.j == '0) begin
      acc_r <= ROUND_C;
    end else if (cmd.op == crp_pkg::OP_ROT_ACC) begin
      acc_r <= acc_r + prod_r;
    end
    if (cmd.op == crp_pkg::OP_ROT_SAT && cmd.i != crp_pkg::LAST_DIM) begin
      tmp_r[cmd.i[0]] <= rnew;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.op == crp_pkg::OP_IDENT) begin
      for (int v = 0; v < crp_pkg::NUM_DIMS; v++) begin
        for (int i = 0; i < crp_pkg::NUM_DIMS; i++) begin
          b_r[v][i] <= (v == i) ? BASIS_ONE : '0;
        end
      end
    end else if (cmd.op == crp_pkg::OP_ROT_SAT && cmd.i == crp_pkg::LAST_DIM) begin
      b_r[cmd.v][0] <= tmp_r[0];
      b_r[cmd.v][1] <= tmp_r[1];
      b_r[cmd.v][2] <= rnew;
    end
  end

  // Face visibility; a zero depth compares the normal against zero.
  always_comb begin
    if (depth_r == '0) begin
      pos_f = b_r[cmd.v][2] > 0;
      neg_f = b_r[cmd.v][2] < 0;
    end else begin
      pos_f = prod_r > FACE_ONE;
      neg_f = prod_r < -FACE_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == crp_pkg::OP_DS_ST) begin
      ds_r   <= prod_r[crp_pkg::DS_W-1:0];
      mask_r <= '0;
    end else if (cmd.op == crp_pkg::OP_FACE_CMP) begin
      mask_r[{cmd.v, 1'b0}] <= pos_f;
      mask_r[{cmd.v, 1'b1}] <= neg_f;
    end
  end

  // Corner sums and perspective denominator.
  always_comb begin
    neg = crp_pkg::CORNER_NEG[cmd.k];
    for (int i = 0; i < crp_pkg::NUM_DIMS; i++) begin
      c_nxt[i] = '0;
      for (int v = 0; v < crp_pkg::NUM_DIMS; v++) begin
        c_nxt[i] = neg[v] ? c_nxt[i] - CW'(b_r[v][i]) : c_nxt[i] + CW'(b_r[v][i]);
      end
    end
    den_nxt = (DEN_W'(depth_r) << FRAC_BITS) - DEN_W'(c_nxt[2]);
  end

  always_ff @(posedge clk) begin
    if (cmd.op == crp_pkg::OP_CORNER) begin
      c_r[0] <= c_nxt[0];
      c_r[1] <= c_nxt[1];
      den_r  <= den_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= 1'b0;
    end else if (cmd.op == crp_pkg::OP_CORNER) begin
      clip_r <= den_nxt <= 0;
    end
  end

  assign mag = prod_r[PW-1] ? -prod_r : prod_r;

  crp_div #(
    .NUM_W (NW),
    .DEN_W (DIV_W)
  ) u_crp_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == crp_pkg::OP_DIV_GO),
    .num   (mag[NW-1:0]),
    .den   (den_r[DIV_W-1:0]),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_comb begin
    q_s   = nneg_r ? -SUM_W'({1'b0, quo}) : SUM_W'({1'b0, quo});
    sum_s = q_s + SUM_W'({1'b0, (cmd.axis ? ctry_r : ctrx_r)});
    if (sum_s > SCR_MAX) sat_s = SCR_MAX[SW-1:0];
    else if (sum_s < SCR_MIN) sat_s = SCR_MIN[SW-1:0];
    else sat_s = sum_s[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == crp_pkg::OP_DIV_GO) begin
      nneg_r <= prod_r[PW-1];
    end
    if (cmd.op == crp_pkg::OP_DIV_ST) begin
      scr_r[cmd.axis] <= sat_s;
    end
  end

  // Output register; it frees itself as soon as the sink takes the corner.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == crp_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == crp_pkg::OP_EMIT) begin
      out_ch.corner_index <= cmd.k;
      out_ch.clipped      <= clip_r;
      out_ch.face_mask    <= mask_r;
      out_ch.last_corner  <= cmd.k == crp_pkg::LAST_CORNER;
      if (clip_r) begin
        out_ch.screen_x <= c_r[0][CW-1] ? SCR_MIN[SW-1:0] : SCR_MAX[SW-1:0];
        out_ch.screen_y <= c_r[1][CW-1] ? SCR_MIN[SW-1:0] : SCR_MAX[SW-1:0];
      end else begin
        out_ch.screen_x <= scr_r[0];
        out_ch.screen_y <= scr_r[1];
      end
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign stat.clip     = clip_r;
  assign stat.div_busy = div_busy;
  assign stat.out_free = !out_valid_r || out_ch.ready;

endmodule

>>> hw/rtl/crp_checker.sv
// Port-level checker for the cube rotate and project block, bound to the top
// level. Depends on crp_pkg and the top level's ports.
`timescale 1ns / 1ps

module crp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [crp_pkg::IDX_W-1:0]   corner_index,
  input logic signed [crp_pkg::SCR_W-1:0] screen_x,
  input logic                        clipped,
  input logic                        last_corner
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("frame accepted while previous frame still in work");

  a_last_is_seven: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_corner |-> corner_index == crp_pkg::LAST_CORNER)
    else $error("last corner flag on wrong corner");

  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clipped |-> screen_x == 16'sh7fff || screen_x == 16'sh8000)
    else $error("clipped corner not saturated");

endmodule

bind cube_rotate_project crp_checker u_crp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .corner_index (out_ch.corner_index),
  .screen_x     (out_ch.screen_x),
  .clipped      (out_ch.clipped),
  .last_corner  (out_ch.last_corner)
);

>>> test/tb.sv
// Self-checking testbench for the cube rotate and project block: drives frame
// transactions and register writes, predicts the eight corner results per frame.
// Depends on crp_pkg, crp_if and the cube_rotate_project top level.
`timescale 1ns / 1ps

module tb;
  import crp_pkg::*;

  localparam int      LIMIT   = 1000000;
  localparam int      ONE_Q14 = 1 << 14;
  localparam longint  B_MAX   = 131071;
  localparam longint  B_MIN   = -131072;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [SCR_W-1:0] x;
    logic signed [SCR_W-1:0] y;
    logic                    clip;
    logic [MASK_W-1:0]       mask;
    logic                    last;
  } corner_res_t;

  // One row of the directed table: either a register write or a frame. A frame
  // row may carry the corner 0 coordinates and face mask typed in by hand.
  typedef struct {
    bit                     is_cfg;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       data;
    bit                     rot;
    bit                     rst;
    bit                     known;
    int                     kx;
    int                     ky;
    int                     kmask;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  crp_in_if  in_ch ();
  crp_out_if out_ch ();

  cube_rotate_project u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: the basis vectors and a shadow of every register.
  logic signed [BASIS_W-1:0] pose [NUM_DIMS*NUM_DIMS];
  logic [CFG_W-1:0]          m_row [NUM_DIMS];
  logic [DEPTH_W-1:0]        depth_r;
  logic [SCALE_W-1:0]        scale_r;
  logic [CTR_W-1:0]          ctr_x_r;
  logic [CTR_W-1:0]          ctr_y_r;

  corner_res_t corners_due [$];
  row_t        plan [$];
  int          errors;
  int          cycles;
  int          frames_sent;
  int          corners_seen;
  int          clip_seen;
  bit          steady;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("tb: mismatch on %s: got %0d, expected %0d (corner result %0d)",
             what, got, want, corners_seen);
    errors++;
  endtask

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  task automatic pose_identity();
    for (int n = 0; n < NUM_DIMS*NUM_DIMS; n++) pose[n] = '0;
    for (int n = 0; n < NUM_DIMS; n++) pose[n*NUM_DIMS+n] = BASIS_W'(ONE_Q14);
  endtask

  // Applies one frame to the predictor and queues the eight corners it yields.
  task automatic predict_frame(input bit rot, input bit rst);
    logic signed [BASIS_W-1:0] nxt [NUM_DIMS*NUM_DIMS];
    longint acc, d, s, c [NUM_DIMS], den, q, sx, sy;
    logic [MASK_W-1:0] mask;
    corner_res_t r;
    if (rst) pose_identity();
    if (rot) begin
      // The whole product uses the old basis, hence the separate copy.
      for (int v = 0; v < NUM_DIMS; v++)
        for (int i = 0; i < NUM_DIMS; i++) begin
          acc = 0;
          for (int j = 0; j < NUM_DIMS; j++)
            acc += longint'($signed(m_row[i][16*j +: 16])) * longint'(pose[v*NUM_DIMS+j]);
          acc = (acc + (1 << (MAT_FRAC - 1))) >>> MAT_FRAC;
          nxt[v*NUM_DIMS+i] = BASIS_W'(clamp(acc, B_MIN, B_MAX));
        end
      pose = nxt;
    end
    d = longint'(depth_r);
    s = longint'(scale_r);
    mask = '0;
    for (int v = 0; v < NUM_DIMS; v++) begin
      acc = longint'(pose[v*NUM_DIMS+2]);
      if (d == 0) begin
        mask[2*v]   = acc > 0;
        mask[2*v+1] = acc < 0;
      end else begin
        mask[2*v]   = acc * d > ONE_Q14;
        mask[2*v+1] = acc * d < -ONE_Q14;
      end
    end
    for (int k = 0; k < NUM_CORNERS; k++) begin
      for (int i = 0; i < NUM_DIMS; i++) begin
        c[i] = 0;
        for (int v = 0; v < NUM_DIMS; v++)
          c[i] += CORNER_NEG[k][v] ? -longint'(pose[v*NUM_DIMS+i])
                                   : longint'(pose[v*NUM_DIMS+i]);
      end
      den = d * ONE_Q14 - c[2];
      r.clip = den <= 0;
      if (r.clip) begin
        sx = (c[0] >= 0) ? 32767 : -32768;
        sy = (c[1] >= 0) ? 32767 : -32768;
      end else begin
        // Division of longint operands truncates toward zero, as required.
        q  = (c[0] * d * s) / den;
        sx = clamp(longint'(ctr_x_r) + q, -32768, 32767);
        q  = (c[1] * d * s) / den;
        sy = clamp(longint'(ctr_y_r) + q, -32768, 32767);
      end
      r.idx  = IDX_W'(k);
      r.x    = SCR_W'(sx);
      r.y    = SCR_W'(sy);
      r.mask = mask;
      r.last = (IDX_W'(k) == LAST_CORNER);
      corners_due.push_back(r);
    end
  endtask

  // Frame transaction: random gaps unless in the steady stretch; valid stays
  // high between back-to-back frames.
  task automatic send_frame(input bit rot, input bit rst);
    if (!steady && $urandom_range(0, 99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.do_rotate <= rot;
    in_ch.restart   <= rst;
    do @(posedge clk); while (!in_ch.ready);
    predict_frame(rot, rst);
    frames_sent++;
  endtask

  // Registers change only once every corner of earlier frames has come out.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    in_ch.valid <= 1'b0;
    while (corners_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MROW0: m_row[0] = data;
      REG_MROW1: m_row[1] = data;
      REG_MROW2: m_row[2] = data;
      REG_DEPTH: depth_r  = data[DEPTH_W-1:0];
      REG_SCALE: scale_r  = data[SCALE_W-1:0];
      REG_CTR_X: ctr_x_r  = data[CTR_W-1:0];
      REG_CTR_Y: ctr_y_r  = data[CTR_W-1:0];
      default: ;
    endcase
  endtask

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    row_t r;
    r = '{default: 0};
    r.is_cfg = 1;
    r.idx    = idx;
    r.data   = data;
    plan.push_back(r);
  endfunction

  function automatic void add_frame(input bit rot, input bit rst, input bit known = 0,
                                    input int kx = 0, input int ky = 0, input int kmask = 0);
    row_t r;
    r = '{default: 0};
    r.rot = rot;  r.rst = rst;
    r.known = known;  r.kx = kx;  r.ky = ky;  r.kmask = kmask;
    plan.push_back(r);
  endfunction

  function automatic logic [CFG_W-1:0] pack_row(input int a, input int b, input int c);
    return {16'(c), 16'(b), 16'(a)};
  endfunction

  // Result side: random back-pressure, comparison against the oldest expectation.
  always @(posedge clk) begin
    corner_res_t w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 6);
      if (out_ch.valid && out_ch.ready) begin
        if (corners_due.size() == 0) begin
          report("unexpected corner index", out_ch.corner_index, -1);
        end else begin
          w = corners_due.pop_front();
          if (out_ch.corner_index !== w.idx)  report("corner_index", out_ch.corner_index, w.idx);
          if (out_ch.screen_x !== w.x)        report("screen_x", out_ch.screen_x, w.x);
          if (out_ch.screen_y !== w.y)        report("screen_y", out_ch.screen_y, w.y);
          if (out_ch.clipped !== w.clip)      report("clipped", out_ch.clipped, w.clip);
          if (out_ch.face_mask !== w.mask)    report("face_mask", out_ch.face_mask, w.mask);
          if (out_ch.last_corner !== w.last)  report("last_corner", out_ch.last_corner, w.last);
          if (w.clip) clip_seen++;
        end
        corners_seen++;
      end
    end
  end

  initial begin
    int off;
    logic [CFG_W-1:0] rows [NUM_DIMS];
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.do_rotate <= 1'b0;
    in_ch.restart   <= 1'b0;
    errors = 0;  cycles = 0;  frames_sent = 0;  corners_seen = 0;  clip_seen = 0;
    steady = 0;
    pose_identity();
    m_row   = '{default: '0};
    depth_r = 8'd5;
    scale_r = 10'd200;
    ctr_x_r = 12'd600;
    ctr_y_r = 12'd400;

    // Directed table. After reset the identity pose puts corner 0 at
    // (600 + 250, 400 + 250) with only the +e3 face showing. A zero matrix
    // collapses the cube onto the centre with no visible face.
    add_frame(0, 0, 1, 850, 650, 6'h10);
    add_frame(0, 1, 1, 850, 650, 6'h10);
    add_frame(1, 0, 1, 600, 400, 6'h00);
    add_frame(1, 1, 1, 600, 400, 6'h00);
    add_cfg(REG_MROW0, pack_row(16384, 0, 0));
    add_cfg(REG_MROW1, pack_row(0, 16384, 0));
    add_cfg(REG_MROW2, pack_row(0, 0, 16384));
    add_frame(1, 1, 1, 850, 650, 6'h10);
    // A small turn about the x axis, applied several times.
    add_cfg(REG_MROW1, pack_row(0, 16345, -1143));
    add_cfg(REG_MROW2, pack_row(0, 1143, 16345));
    add_frame(1, 0);  add_frame(1, 0);  add_frame(1, 0);
    // Largest and most negative entries drive the basis into saturation.
    for (int n = 0; n < NUM_DIMS; n++)
      add_cfg(CFG_IDX_W'(REG_MROW0 + n), 48'h7FFF_7FFF_7FFF);
    add_frame(1, 0);  add_frame(1, 0);
    for (int n = 0; n < NUM_DIMS; n++)
      add_cfg(CFG_IDX_W'(REG_MROW0 + n), 48'h8000_8000_8000);
    add_frame(1, 0);
    for (int n = 0; n < NUM_DIMS; n++)
      add_cfg(CFG_IDX_W'(REG_MROW0 + n), 48'hFFFF_FFFF_FFFF);
    add_frame(1, 1);
    // Viewer at depth one: corners in front of the eye are clipped.
    add_cfg(REG_DEPTH, 48'd1);
    add_frame(0, 1);
    // Zero depth: threshold falls to zero and unclipped corners sit at the centre.
    add_cfg(REG_DEPTH, 48'd0);
    add_frame(0, 1);
    add_cfg(REG_DEPTH, 48'd255);
    add_cfg(REG_SCALE, 48'd1023);
    add_cfg(REG_CTR_X, 48'd4095);
    add_cfg(REG_CTR_Y, 48'd4095);
    add_frame(0, 1);
    add_cfg(REG_SCALE, 48'd0);
    add_cfg(REG_CTR_X, 48'd0);
    add_cfg(REG_CTR_Y, 48'd0);
    add_frame(0, 0);
    add_cfg(REG_DEPTH, 48'd5);
    add_cfg(REG_SCALE, 48'd200);
    add_cfg(REG_CTR_X, 48'd600);
    add_cfg(REG_CTR_Y, 48'd400);
    add_frame(0, 1);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[p]) begin
      if (plan[p].is_cfg) begin
        write_reg(plan[p].idx, plan[p].data);
      end else begin
        send_frame(plan[p].rot, plan[p].rst);
        if (plan[p].known) begin
          // Corner 0 of this frame takes the hand-typed values.
          off = corners_due.size() - NUM_CORNERS;
          corners_due[off].x    = SCR_W'(plan[p].kx);
          corners_due[off].y    = SCR_W'(plan[p].ky);
          corners_due[off].mask = MASK_W'(plan[p].kmask);
        end
      end
    end

    // Random phases: a fresh register setting, then a run of frames. Most
    // matrices are near rotations so the pose wanders rather than collapsing.
    for (int ph = 0; ph < 10; ph++) begin
      steady = (ph == 4 || ph == 5);
      for (int n = 0; n < NUM_DIMS; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          rows[n] = '0;
          for (int j = 0; j < NUM_DIMS; j++)
            rows[n][16*j +: 16] = (j == n) ? 16'(16300 + $urandom_range(0, 84))
                                           : 16'($signed($urandom_range(0, 1200)) - 600);
        end else begin
          rows[n] = CFG_W'({$urandom, $urandom});
        end
        write_reg(CFG_IDX_W'(REG_MROW0 + n), rows[n]);
      end
      case ($urandom_range(0, 5))
        0:       write_reg(REG_DEPTH, 48'($urandom_range(0, 1)));
        1:       write_reg(REG_DEPTH, 48'd255);
        2:       write_reg(REG_DEPTH, 48'($urandom_range(1, 255)));
        default: write_reg(REG_DEPTH, 48'($urandom_range(2, 8)));
      endcase
      write_reg(REG_SCALE, 48'($urandom_range(0, 1023)));
      write_reg(REG_CTR_X, 48'($urandom_range(0, 4095)));
      write_reg(REG_CTR_Y, 48'($urandom_range(0, 4095)));
      for (int f = 0; f < 31; f++)
        send_frame($urandom_range(0, 9) != 0, $urandom_range(0, 19) == 0);
      in_ch.valid <= 1'b0;
    end
    steady = 0;

    while (corners_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("tb: %0d frames sent, %0d corner transactions checked, %0d of them clipped",
             frames_sent, corners_seen, clip_seen);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
